// File: design/expsrch_pkg.sv
`timescale 1ns / 1ps

package expsrch_pkg;

  // Default geometry of the table
  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths fixed by the interface
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Search sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXP  = 2'd1,
    S_BMID = 2'd2,
    S_BCMP = 2'd3
  } state_t;

endpackage

// File: design/exponential_search_sorted_table.sv
`timescale 1ns / 1ps
// Clear, append and no-op give their result in the cycle after the transfer.
// Search: one read per galloping probe (index 2^p-1), then each binary probe that
// reads takes a midpoint state and then a compare of the memory read, and a
// midpoint past the end takes a midpoint state with no read.
// One command at a time; busy is high while a search runs.
// Reset (synchronous, rst high) empties the table; table contents are not cleared.
// Results show for one cycle on done; the receiver cannot stall them.
module exponential_search_sorted_table #(
  parameter int DEPTH      = expsrch_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = expsrch_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [expsrch_pkg::CMD_W-1:0]       command,
  input  logic signed [expsrch_pkg::VALUE_W-1:0] value,
  output logic                                done,
  output logic [expsrch_pkg::STATUS_W-1:0]    status,
  output logic [expsrch_pkg::INDEX_W-1:0]     found_index
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 1;

  expsrch_pkg::state_t state, state_next;

  logic [CW-1:0]         count, count_next;
  logic                  done_next;
  logic [PW-1:0]         probe, probe_next;
  logic [PW-1:0]         lo, lo_next;
  logic [PW-1:0]         hi, hi_next;
  logic [DATA_WIDTH-1:0] key, key_next;
  expsrch_pkg::status_t  status_q, status_next;
  logic [PW-1:0]         index_next;
  logic [PW+expsrch_pkg::INDEX_W-1:0] index_wide;

  // Memory port signals
  logic                  we, re;
  logic [PW-1:0]         rd_probe;
  logic [DATA_WIDTH-1:0] rdata;

  // Compare and probe arithmetic
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] key_in;
  logic [PW-1:0]         count_ext;
  logic                  cmp_eq, cmp_gt;
  logic [PW-1:0]         exp_step;
  logic                  exp_step_in;
  logic [PW:0]           mid_sum;
  logic [PW-1:0]         mid;
  logic                  mid_in, bin_empty;
  expsrch_pkg::cmd_t     cmd;

  assign cmd         = expsrch_pkg::cmd_t'(command);
  assign value_ext   = {{(64 - expsrch_pkg::VALUE_W){value[expsrch_pkg::VALUE_W-1]}}, value};
  assign key_in      = value_ext[DATA_WIDTH-1:0];
  assign count_ext   = {1'b0, count};
  assign cmp_eq      = (rdata == key);
  assign cmp_gt      = ($signed(rdata) > $signed(key));
  assign exp_step    = {probe[PW-2:0], 1'b1};
  assign exp_step_in = (exp_step < count_ext);
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid         = mid_sum[PW:1];
  assign mid_in      = (mid < count_ext);
  assign bin_empty   = (lo > hi);
  assign busy        = (state != expsrch_pkg::S_IDLE);

  expsrch_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (key_in),
    .re    (re),
    .raddr (rd_probe[AW-1:0]),
    .rdata (rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      expsrch_pkg::S_IDLE: begin
        if (start && (cmd == expsrch_pkg::CMD_SEARCH) && (count != '0)) begin
          state_next = expsrch_pkg::S_EXP;
        end
      end
      expsrch_pkg::S_EXP: begin
        if (cmp_eq) begin
          state_next = expsrch_pkg::S_IDLE;
        end else if (cmp_gt) begin
          state_next = (probe == '0) ? expsrch_pkg::S_IDLE : expsrch_pkg::S_BMID;
        end else if (!exp_step_in) begin
          state_next = expsrch_pkg::S_BMID;
        end
      end
      expsrch_pkg::S_BMID: begin
        if (bin_empty) begin
          state_next = expsrch_pkg::S_IDLE;
        end else if (mid_in) begin
          state_next = expsrch_pkg::S_BCMP;
        end
      end
      expsrch_pkg::S_BCMP: begin
        state_next = expsrch_pkg::S_BMID;
        if (cmp_eq) begin
          state_next = expsrch_pkg::S_IDLE;
        end
      end
      default: state_next = expsrch_pkg::S_IDLE;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    count_next  = count;
    done_next   = 1'b0;
    probe_next  = probe;
    lo_next     = lo;
    hi_next     = hi;
    key_next    = key;
    status_next = expsrch_pkg::ST_DONE;
    index_next  = '0;
    we          = 1'b0;
    re          = 1'b0;
    rd_probe    = probe;
    case (state)
      expsrch_pkg::S_IDLE: begin
        if (start) begin
          case (cmd)
            expsrch_pkg::CMD_CLEAR: begin
              count_next = '0;
              done_next  = 1'b1;
            end
            expsrch_pkg::CMD_APPEND: begin
              done_next = 1'b1;
              if (count < CW'(DEPTH)) begin
                we         = 1'b1;
                count_next = count + 1'b1;
              end else begin
                status_next = expsrch_pkg::ST_FULL;
              end
            end
            expsrch_pkg::CMD_SEARCH: begin
              key_next = key_in;
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = expsrch_pkg::ST_NOT_FOUND;
              end else begin
                re         = 1'b1;
                rd_probe   = '0;
                probe_next = '0;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      // Gallop over indices 2^p-1, one read per cycle
      expsrch_pkg::S_EXP: begin
        if (cmp_eq) begin
          done_next   = 1'b1;
          status_next = expsrch_pkg::ST_FOUND;
          index_next  = probe;
        end else if (cmp_gt) begin
          if (probe == '0) begin
            done_next   = 1'b1;
            status_next = expsrch_pkg::ST_NOT_FOUND;
          end else begin
            lo_next = PW'((probe + 1'b1) >> 1);
            hi_next = probe - 1'b1;
          end
        end else if (exp_step_in) begin
          re         = 1'b1;
          rd_probe   = exp_step;
          probe_next = exp_step;
        end else begin
          lo_next = probe + 1'b1;
          hi_next = {probe[PW-2:0], 1'b0};
        end
      end
      // Pick the midpoint; past the end counts as larger
      expsrch_pkg::S_BMID: begin
        if (bin_empty) begin
          done_next   = 1'b1;
          status_next = expsrch_pkg::ST_NOT_FOUND;
        end else if (mid_in) begin
          re         = 1'b1;
          rd_probe   = mid;
          probe_next = mid;
        end else begin
          hi_next = mid - 1'b1;
        end
      end
      // Narrow the range from the read entry
      expsrch_pkg::S_BCMP: begin
        if (cmp_eq) begin
          done_next   = 1'b1;
          status_next = expsrch_pkg::ST_FOUND;
          index_next  = probe;
        end else if (cmp_gt) begin
          hi_next = probe - 1'b1;
        end else begin
          lo_next = probe + 1'b1;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  assign index_wide = (PW + expsrch_pkg::INDEX_W)'(index_next);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= expsrch_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    probe       <= probe_next;
    lo          <= lo_next;
    hi          <= hi_next;
    key         <= key_next;
    status_q    <= status_next;
    found_index <= index_wide[expsrch_pkg::INDEX_W-1:0];
  end

  assign status = status_q;

endmodule

// File: design/expsrch_mem.sv
`timescale 1ns / 1ps

module expsrch_mem #(
  parameter int DEPTH      = expsrch_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = expsrch_pkg::DATA_WIDTH_DEF,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/expsrch_chk.sv
`timescale 1ns / 1ps

module expsrch_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   start,
  input logic                                   busy,
  input logic [expsrch_pkg::CMD_W-1:0]          command,
  input logic signed [expsrch_pkg::VALUE_W-1:0] value,
  input logic                                   done,
  input logic [expsrch_pkg::STATUS_W-1:0]       status,
  input logic [expsrch_pkg::INDEX_W-1:0]        found_index
);

  logic xfer;
  assign xfer = start && !busy;

  // Clear answers done in the next cycle
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    xfer && (command == expsrch_pkg::CMD_CLEAR) |=>
      done && (status == expsrch_pkg::ST_DONE) && (found_index == '0))
    else $error("clear did not answer done");

  // Append reports only done or full
  a_append_status: assert property (@(posedge clk) disable iff (rst)
    xfer && (command == expsrch_pkg::CMD_APPEND) |=>
      done && ((status == expsrch_pkg::ST_DONE) || (status == expsrch_pkg::ST_FULL)))
    else $error("append gave a search status");

  // Index is zero unless found
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != expsrch_pkg::ST_FOUND) |-> (found_index == '0))
    else $error("index set without a hit");

  // A search either runs or answers at once
  a_search_runs: assert property (@(posedge clk) disable iff (rst)
    xfer && (command == expsrch_pkg::CMD_SEARCH) |=> busy || done)
    else $error("search dropped");

  // A result follows a transfer or a running search
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a command");

endmodule

bind exponential_search_sorted_table expsrch_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .command     (command),
  .value       (value),
  .done        (done),
  .status      (status),
  .found_index (found_index)
);

// File: bench/exponential_search_sorted_table_tb.sv
`timescale 1ns / 1ps

module exponential_search_sorted_table_tb;

  localparam int TABLE_DEPTH = expsrch_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    expsrch_pkg::status_t              st;
    logic [expsrch_pkg::INDEX_W-1:0]   idx;
  } reply_t;

  // Mirror of the table contents plus the queue of replies still owed by the block
  class table_shadow;
    logic signed [expsrch_pkg::VALUE_W-1:0] entries [TABLE_DEPTH];
    int                                     fill;
    reply_t                                 pending_replies [$];
    int                                     errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Compare one entry with the key: -1 less, 0 equal, 1 larger or past the end
    function int probe(int pos, logic signed [expsrch_pkg::VALUE_W-1:0] key);
      if (pos >= fill || pos >= TABLE_DEPTH) return 1;
      if (entries[pos] == key) return 0;
      return (entries[pos] > key) ? 1 : -1;
    endfunction

    // Gallop over indices 2^p-1, then bisect the last bracket
    function int locate_key(logic signed [expsrch_pkg::VALUE_W-1:0] key);
      int p, lo, hi, mid, c;
      p = 0;
      c = probe(0, key);
      while (c < 0) begin
        p++;
        c = probe((1 << p) - 1, key);
      end
      if (c == 0) return (1 << p) - 1;
      if (p == 0) return -1;
      lo = 1 << (p - 1);
      hi = (1 << p) - 2;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        c = probe(mid, key);
        if (c == 0) return mid;
        if (c > 0) hi = mid - 1;
        else lo = mid + 1;
      end
      return -1;
    endfunction

    // Apply an accepted command and queue the reply it must produce
    function void note_command(expsrch_pkg::cmd_t cmd,
                               logic signed [expsrch_pkg::VALUE_W-1:0] val);
      reply_t r;
      int     hit;
      r.st  = expsrch_pkg::ST_DONE;
      r.idx = '0;
      case (cmd)
        expsrch_pkg::CMD_CLEAR: begin
          fill = 0;
        end
        expsrch_pkg::CMD_APPEND: begin
          if (fill < TABLE_DEPTH) begin
            entries[fill] = val;
            fill++;
          end else begin
            r.st = expsrch_pkg::ST_FULL;
          end
        end
        expsrch_pkg::CMD_SEARCH: begin
          hit = locate_key(val);
          if (hit >= 0) begin
            r.st  = expsrch_pkg::ST_FOUND;
            r.idx = hit[expsrch_pkg::INDEX_W-1:0];
          end else begin
            r.st = expsrch_pkg::ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Compare a delivered reply with the oldest one owed
    task check_reply(logic [expsrch_pkg::STATUS_W-1:0] st,
                     logic [expsrch_pkg::INDEX_W-1:0] idx);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply status=%0d index=%0d with nothing pending", st, idx));
        return;
      end
      exp = pending_replies.pop_front();
      if (st !== exp.st)
        report($sformatf("status %0d, expected %s", st, exp.st.name()));
      if (idx !== exp.idx)
        report($sformatf("found_index %0d, expected %0d", idx, exp.idx));
    endtask
  endclass

  logic                                    clk;
  logic                                    rst;
  logic                                    start;
  logic                                    busy;
  logic [expsrch_pkg::CMD_W-1:0]           command;
  logic signed [expsrch_pkg::VALUE_W-1:0]  value;
  logic                                    done;
  logic [expsrch_pkg::STATUS_W-1:0]        status;
  logic [expsrch_pkg::INDEX_W-1:0]         found_index;

  table_shadow shadow;
  bit          gaps_on;
  int          cycle_count = 0;

  exponential_search_sorted_table DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_index (found_index)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check every strobed reply
  always @(posedge clk) begin
    if (!rst && done) shadow.check_reply(status, found_index);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive one command, with an optional random gap, and hold it until the transfer
  task issue(expsrch_pkg::cmd_t cmd, logic signed [expsrch_pkg::VALUE_W-1:0] val);
    if (gaps_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    value   <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.note_command(cmd, val);
  endtask

  // Hold off the sender until every owed reply has arrived
  task drain_replies();
    start <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
  endtask

  task run_directed();
    issue(expsrch_pkg::CMD_NOP, 32'shFFFF_FFFF);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd0);
    issue(expsrch_pkg::CMD_APPEND, 32'sh8000_0000);
    issue(expsrch_pkg::CMD_SEARCH, 32'sh8000_0000);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd5);
    issue(expsrch_pkg::CMD_APPEND, -32'sd100);
    issue(expsrch_pkg::CMD_APPEND, -32'sd100);
    issue(expsrch_pkg::CMD_APPEND, 32'sd0);
    issue(expsrch_pkg::CMD_APPEND, 32'sd7);
    issue(expsrch_pkg::CMD_APPEND, 32'sd7);
    issue(expsrch_pkg::CMD_APPEND, 32'sd42);
    issue(expsrch_pkg::CMD_APPEND, 32'sd1000);
    issue(expsrch_pkg::CMD_APPEND, 32'sh7FFF_FFFF);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd7);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd1000);
    issue(expsrch_pkg::CMD_SEARCH, 32'sh7FFF_FFFF);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd41);
    issue(expsrch_pkg::CMD_SEARCH, -32'sd100);
    issue(expsrch_pkg::CMD_CLEAR, 32'sd0);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd0);
    // first entry above the key
    issue(expsrch_pkg::CMD_APPEND, 32'sd10);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd3);
    // out-of-order append: the probe sequence misses the present value
    issue(expsrch_pkg::CMD_APPEND, 32'sd5);
    issue(expsrch_pkg::CMD_SEARCH, 32'sd5);
    issue(expsrch_pkg::CMD_NOP, 32'sd0);
  endtask

  // Mostly well-formed runs: clear, sorted appends, searches; the rest is noise
  task run_random(int target);
    int                                      sent, n, k, i, pick;
    longint                                  cur;
    logic signed [expsrch_pkg::VALUE_W-1:0]  run_vals [$];
    logic signed [expsrch_pkg::VALUE_W-1:0]  key;
    sent = 0;
    while (sent < target) begin
      gaps_on = !(sent >= 150 && sent < 230);
      if ($urandom_range(99) < 75) begin
        run_vals.delete();
        issue(expsrch_pkg::CMD_CLEAR, $urandom);
        sent++;
        n = ($urandom_range(9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 12);
        case ($urandom_range(3))
          0:       cur = longint'(32'sh8000_0000);
          1:       cur = longint'($signed($urandom)) >>> 1;
          default: cur = longint'($signed($urandom_range(0, 2000))) - 1000;
        endcase
        for (i = 0; i < n; i++) begin
          run_vals.push_back(cur[expsrch_pkg::VALUE_W-1:0]);
          issue(expsrch_pkg::CMD_APPEND, cur[expsrch_pkg::VALUE_W-1:0]);
          sent++;
          if ($urandom_range(3) != 0)
            cur += $urandom_range(0, 1 << $urandom_range(0, 24));
          if (cur > 2147483647) cur = 2147483647;
        end
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++) begin
          pick = $urandom_range(99);
          if (run_vals.size() != 0 && pick < 60)
            key = run_vals[$urandom_range(run_vals.size() - 1)];
          else if (run_vals.size() != 0 && pick < 80)
            key = run_vals[$urandom_range(run_vals.size() - 1)] +
                  (($urandom_range(1) != 0) ? 32'sd1 : -32'sd1);
          else if (pick < 85)
            key = ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          else
            key = $urandom;
          issue(expsrch_pkg::CMD_SEARCH, key);
          sent++;
        end
      end else begin
        issue(expsrch_pkg::cmd_t'($urandom_range(0, 3)), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    shadow      = new();
    gaps_on     = 1'b1;
    rst         = 1'b1;
    start       <= 1'b0;
    command     <= expsrch_pkg::CMD_NOP;
    value       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain_replies();
    run_random(370);

    // Let the last replies land, then watch for stray strobes
    drain_replies();
    repeat (40) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
